// ----- hw/rtl/cgt_pkg.sv -----
`default_nettype none

package cgt_pkg;

  localparam int unsigned NumStages = 6;

  localparam logic [29:0] MsPerWeek = 30'd604800000;
  localparam logic [26:0] MsPerDay  = 27'd86400000;
  localparam logic [21:0] MsPerHour = 22'd3600000;
  localparam logic [15:0] MsPerMin  = 16'd60000;
  localparam logic [11:0] EpochYear = 12'd1980;
  // Julian day of the epoch plus the algorithm offset
  localparam logic [21:0] JdBase    = 22'd2445782;
  localparam logic [12:0] YearBase  = 13'd4715;
  // 7 * 2^17: keeps the day count positive and leaves week mod 8192 untouched
  localparam logic [20:0] Div7Bias  = 21'd917504;

  // exact floor division by constants: x / d == (x * ceil(2^k / d)) >> k
  localparam int unsigned Div7Shift  = 27;
  localparam int unsigned DayShift   = 57;
  localparam int unsigned JulShift   = 39;
  localparam int unsigned MinShift   = 43;
  localparam int unsigned HourShift  = 17;
  localparam int unsigned MonShift   = 43;
  localparam int unsigned DomShift   = 39;

  localparam logic [24:0] RecipDiv7 =
    25'(((64'd1 << Div7Shift) + 64'd6) / 64'd7);
  localparam logic [30:0] RecipDay =
    31'(((64'd1 << DayShift) + 64'd86399999) / 64'd86400000);
  localparam logic [26:0] RecipJul =
    27'(((64'd1 << JulShift) + 64'd7304) / 64'd7305);
  localparam logic [27:0] RecipMin =
    28'(((64'd1 << MinShift) + 64'd59999) / 64'd60000);
  localparam logic [11:0] RecipHour =
    12'(((64'd1 << HourShift) + 64'd59) / 64'd60);
  // (x * 10000) / 306001 with the 10000 folded into the constant
  localparam logic [38:0] ScaleMon =
    39'(64'd10000 * (((64'd1 << MonShift) + 64'd306000) / 64'd306001));
  // (x * 306001) / 10000 with the 306001 folded into the constant
  localparam logic [43:0] ScaleDom =
    44'(64'd306001 * (((64'd1 << DomShift) + 64'd9999) / 64'd10000));

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] millis;
  } cgt_cal_t;

  typedef struct packed {
    logic [12:0] week;
    logic [29:0] week_millis;
  } cgt_gps_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
    logic                 out_op;
  } cgt_ctrl_t;

  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] res;
    unique case (month)
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cgt_if.sv -----
`default_nettype none

interface cgt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [11:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic [5:0]  cal_minute;
  logic [15:0] cal_millis;
  logic [12:0] in_week;
  logic [29:0] in_week_millis;

  modport source (
    output valid, operation, cal_year, cal_month, cal_day, cal_hour, cal_minute,
           cal_millis, in_week, in_week_millis,
    input  ready
  );
  modport sink (
    input  valid, operation, cal_year, cal_month, cal_day, cal_hour, cal_minute,
           cal_millis, in_week, in_week_millis,
    output ready
  );
endinterface

interface cgt_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] out_week;
  logic [29:0] out_week_millis;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [15:0] out_millis;

  modport source (
    output valid, out_week, out_week_millis, out_year, out_month, out_day,
           out_hour, out_minute, out_millis,
    input  ready
  );
  modport sink (
    input  valid, out_week, out_week_millis, out_year, out_month, out_day,
           out_hour, out_minute, out_millis,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/cgt_ctrl.sv -----
`default_nettype none

module cgt_ctrl import cgt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_op_i,
  input  wire logic      out_ready_i,
  output cgt_ctrl_t      ctrl_o
);

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] op_q, op_d;
  logic [NumStages-1:0] en;

  // a stage loads when empty or when its item moves on
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    op_d  = op_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
      op_d[0]  = in_op_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
        op_d[k]  = op_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign ctrl_o.en     = en;
  assign ctrl_o.vld    = vld_q;
  assign ctrl_o.out_op = op_q[NumStages-1];

endmodule

`default_nettype wire

// ----- hw/rtl/cgt_d2g.sv -----
`default_nettype none

module cgt_d2g import cgt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [NumStages-1:0] en_i,
  input  wire cgt_cal_t             cal_i,
  output cgt_gps_t                  gps_o
);

  // stage 1: biased day count since epoch, time of day
  logic [3:0]  mon;
  logic [12:0] yr;
  logic [20:0] yr_ext, leap, u_d;
  logic [26:0] tod_d;

  always_comb begin
    priority if (cal_i.month == 4'd0) begin
      mon = 4'd1;
    end else if (cal_i.month > 4'd12) begin
      mon = 4'd12;
    end else begin
      mon = cal_i.month;
    end
    yr     = {1'b0, cal_i.year} - {1'b0, EpochYear};
    yr_ext = {{8{yr[12]}}, yr};
    leap   = {{10{yr[12]}}, yr[12:2]} + 21'd1;
    if (yr[1:0] == 2'b00 && mon <= 4'd2) begin
      leap = leap - 21'd1;
    end
    // modulo 2^21 arithmetic; the true sum lies in range
    u_d = yr_ext * 21'd365 + 21'(cum_days(mon)) + 21'(cal_i.day) + leap - 21'd6
        + Div7Bias;
    tod_d = 27'(cal_i.hour) * 27'(MsPerHour) + 27'(cal_i.minute) * 27'(MsPerMin)
          + 27'(cal_i.millis);
  end

  logic [20:0] u1_q;
  logic [26:0] tod1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u1_q   <= u_d;
      tod1_q <= tod_d;
    end
  end

  // stage 2: weeks = days / 7
  logic [45:0] prod7;
  assign prod7 = 46'(u1_q) * 46'(RecipDiv7);

  logic [18:0] q2_q;
  logic [20:0] u2_q;
  logic [26:0] tod2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q2_q   <= prod7[45:Div7Shift];
      u2_q   <= u1_q;
      tod2_q <= tod1_q;
    end
  end

  // stage 3: day of week to millis, add time of day
  logic [20:0] rem_full;
  logic [29:0] s_d;
  assign rem_full = u2_q - 21'(q2_q) * 21'd7;
  assign s_d      = 30'(rem_full[2:0]) * 30'(MsPerDay) + 30'(tod2_q);

  logic [12:0] wk3_q;
  logic [29:0] s3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      wk3_q <= q2_q[12:0];
      s3_q  <= s_d;
    end
  end

  // stage 4: carry an overflowing week
  logic [12:0] wk4_d;
  logic [29:0] ms4_d;

  always_comb begin
    if (s3_q >= MsPerWeek) begin
      wk4_d = wk3_q + 13'd1;
      ms4_d = s3_q - MsPerWeek;
    end else begin
      wk4_d = wk3_q;
      ms4_d = s3_q;
    end
  end

  cgt_gps_t gps4_q, gps5_q, gps6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      gps4_q.week        <= wk4_d;
      gps4_q.week_millis <= ms4_d;
    end
    if (en_i[4]) begin
      gps5_q <= gps4_q;
    end
    if (en_i[5]) begin
      gps6_q <= gps5_q;
    end
  end

  assign gps_o = gps6_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cgt_g2d.sv -----
`default_nettype none

module cgt_g2d import cgt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [NumStages-1:0] en_i,
  input  wire cgt_gps_t             gps_i,
  output cgt_cal_t                  cal_o
);

  // stage 1: whole days in the week millis
  logic [60:0] prod_day;
  assign prod_day = 61'(gps_i.week_millis) * 61'(RecipDay);

  logic [3:0]  q1_q;
  logic [29:0] wms1_q;
  logic [12:0] week1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q1_q    <= prod_day[60:DayShift];
      wms1_q  <= gps_i.week_millis;
      week1_q <= gps_i.week;
    end
  end

  // stage 2: Julian day, numerator of the year step, millis of day
  logic [21:0] c_d;
  logic [25:0] n_d;
  logic [29:0] msd_full;

  assign c_d      = 22'(week1_q) * 22'd7 + 22'(q1_q) + JdBase;
  assign n_d      = 26'(c_d) * 26'd20 - 26'd2442;
  assign msd_full = wms1_q - 30'(q1_q) * 30'(MsPerDay);

  logic [21:0] c2_q;
  logic [25:0] n2_q;
  logic [26:0] msd2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      c2_q   <= c_d;
      n2_q   <= n_d;
      msd2_q <= msd_full[26:0];
    end
  end

  // stage 3: d = (20c - 2442) / 7305, minutes of day
  logic [52:0] prod_jul;
  logic [54:0] prod_min;
  assign prod_jul = 53'(n2_q) * 53'(RecipJul);
  assign prod_min = 55'(msd2_q) * 55'(RecipMin);

  logic [12:0] d3_q;
  logic [10:0] mins3_q;
  logic [21:0] c3_q;
  logic [26:0] msd3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      d3_q    <= prod_jul[JulShift+12:JulShift];
      mins3_q <= prod_min[MinShift+10:MinShift];
      c3_q    <= c2_q;
      msd3_q  <= msd2_q;
    end
  end

  // stage 4: day of the shifted year, hour, minute, millis
  logic [21:0] e_d;
  logic [21:0] cme_full;
  logic [22:0] prod_hour;
  logic [4:0]  hour_d;
  logic [10:0] min_full;
  logic [26:0] ms_full;

  assign e_d       = 22'(d3_q) * 22'd365 + 22'(d3_q[12:2]);
  assign cme_full  = c3_q - e_d;
  assign prod_hour = 23'(mins3_q) * 23'(RecipHour);
  assign hour_d    = prod_hour[HourShift+4:HourShift];
  assign min_full  = mins3_q - 11'(hour_d) * 11'd60;
  assign ms_full   = msd3_q - 27'(mins3_q) * 27'(MsPerMin);

  logic [9:0]  cme4_q;
  logic [12:0] d4_q;
  logic [4:0]  hour4_q;
  logic [5:0]  min4_q;
  logic [15:0] ms4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      cme4_q  <= cme_full[9:0];
      d4_q    <= d3_q;
      hour4_q <= hour_d;
      min4_q  <= min_full[5:0];
      ms4_q   <= ms_full[15:0];
    end
  end

  // stage 5: f = (c - e) * 10000 / 306001
  logic [48:0] prod_mon;
  assign prod_mon = 49'(cme4_q) * 49'(ScaleMon);

  logic [5:0]  f5_q;
  logic [9:0]  cme5_q;
  logic [12:0] d5_q;
  logic [4:0]  hour5_q;
  logic [5:0]  min5_q;
  logic [15:0] ms5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      f5_q    <= prod_mon[MonShift+5:MonShift];
      cme5_q  <= cme4_q;
      d5_q    <= d4_q;
      hour5_q <= hour4_q;
      min5_q  <= min4_q;
      ms5_q   <= ms4_q;
    end
  end

  // stage 6: day, month, year
  logic [49:0] prod_dom;
  logic [10:0] g_d;
  logic [10:0] day_full;
  logic [5:0]  q14;
  logic [5:0]  mon_full;
  logic [12:0] year_full;

  always_comb begin
    prod_dom = 50'(f5_q) * 50'(ScaleDom);
    g_d      = prod_dom[DomShift+10:DomShift];
    day_full = 11'(cme5_q) - g_d;
    priority if (f5_q >= 6'd28) begin
      q14 = 6'd2;
    end else if (f5_q >= 6'd14) begin
      q14 = 6'd1;
    end else begin
      q14 = 6'd0;
    end
    mon_full  = f5_q - 6'd1 - q14 * 6'd12;
    year_full = d5_q - YearBase;
    if (mon_full >= 6'd3) begin
      year_full = year_full - 13'd1;
    end
  end

  cgt_cal_t cal6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      cal6_q.year   <= year_full[11:0];
      cal6_q.month  <= mon_full[3:0];
      cal6_q.day    <= day_full[4:0];
      cal6_q.hour   <= hour5_q;
      cal6_q.minute <= min5_q;
      cal6_q.millis <= ms5_q;
    end
  end

  assign cal_o = cal6_q;

endmodule

`default_nettype wire

// ----- hw/rtl/calendar_gps_time_convert.sv -----
// Throughput: one item per cycle while the output is not stalled; six
// register stages, each holding at most one constant-reciprocal multiply
// per path, set the depth.
// A stalled output holds its item; empty stages upstream keep accepting.
// Reset clears the stage valid bits only; there is no clearing pass.
`default_nettype none

module calendar_gps_time_convert import cgt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cgt_in_if.sink    in_i,
  cgt_out_if.source out_o
);

  cgt_ctrl_t ctrl;
  cgt_cal_t  cal_in, cal_res;
  cgt_gps_t  gps_in, gps_res;

  cgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  assign cal_in.year   = in_i.cal_year;
  assign cal_in.month  = in_i.cal_month;
  assign cal_in.day    = in_i.cal_day;
  assign cal_in.hour   = in_i.cal_hour;
  assign cal_in.minute = in_i.cal_minute;
  assign cal_in.millis = in_i.cal_millis;

  assign gps_in.week        = in_i.in_week;
  assign gps_in.week_millis = in_i.in_week_millis;

  cgt_d2g u_d2g (
    .clk_i (clk_i),
    .en_i  (ctrl.en),
    .cal_i (cal_in),
    .gps_o (gps_res)
  );

  cgt_g2d u_g2d (
    .clk_i (clk_i),
    .en_i  (ctrl.en),
    .gps_i (gps_in),
    .cal_o (cal_res)
  );

  assign in_i.ready = ctrl.en[0];
  assign out_o.valid = ctrl.vld[NumStages-1];

  // fields of the other direction read as zero
  always_comb begin
    if (ctrl.out_op) begin
      out_o.out_week        = '0;
      out_o.out_week_millis = '0;
      out_o.out_year        = cal_res.year;
      out_o.out_month       = cal_res.month;
      out_o.out_day         = cal_res.day;
      out_o.out_hour        = cal_res.hour;
      out_o.out_minute      = cal_res.minute;
      out_o.out_millis      = cal_res.millis;
    end else begin
      out_o.out_week        = gps_res.week;
      out_o.out_week_millis = gps_res.week_millis;
      out_o.out_year        = '0;
      out_o.out_month       = '0;
      out_o.out_day         = '0;
      out_o.out_hour        = '0;
      out_o.out_minute      = '0;
      out_o.out_millis      = '0;
    end
  end

  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&ctrl.vld) |-> in_i.ready)
    else $error("input stalled with a free pipeline stage");

  a_week_millis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !ctrl.out_op |-> out_o.out_week_millis < MsPerWeek)
    else $error("millis of week not reduced below one week");

  a_time_of_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && ctrl.out_op |->
      out_o.out_month >= 4'd1 && out_o.out_month <= 4'd12 &&
      out_o.out_hour < 5'd24 && out_o.out_minute < 6'd60 &&
      out_o.out_millis < MsPerMin)
    else $error("calendar result out of range");

endmodule

`default_nettype wire

// ----- dv/calendar_gps_time_convert_tb.sv -----
`default_nettype none

module calendar_gps_time_convert_tb;
  import cgt_pkg::cgt_cal_t;
  import cgt_pkg::cgt_gps_t;

  localparam logic OpCalToGps = 1'b0;
  localparam logic OpGpsToCal = 1'b1;

  localparam longint DayMs          = 86400000;
  localparam longint HourMs         = 3600000;
  localparam longint MinuteMs       = 60000;
  localparam longint WeekMs         = 604800000;
  localparam longint GpsEpochYear   = 1980;
  localparam longint JulianEpoch    = 2444245;
  localparam longint JulianOffset   = 1537;
  localparam longint JulianYearBase = 4715;

  localparam int NumRandom   = 1900;
  localparam int IdlePct     = 38;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 12;
  localparam int NumDirected = 21;

  localparam int MonthStart [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic     op;
    cgt_cal_t cal;
    cgt_gps_t gps;
  } time_req_t;

  typedef struct packed {
    cgt_gps_t gps;
    cgt_cal_t cal;
  } time_res_t;

  typedef struct packed {
    time_req_t req;
    logic      known;
    time_res_t want;
  } dir_row_t;

  localparam cgt_cal_t  NoCal = '0;
  localparam cgt_gps_t  NoGps = '0;
  localparam time_res_t NoRes = '0;

  // known rows: epoch, day before epoch, one week on, and the first week seen from GPS side
  localparam dir_row_t Directed [NumDirected] = '{
    '{'{OpCalToGps, '{12'd1980, 4'd1, 5'd6, 5'd0, 6'd0, 16'd0}, NoGps}, 1'b1,
      '{'{13'd0, 30'd0}, NoCal}},
    '{'{OpCalToGps, '{12'd1980, 4'd1, 5'd5, 5'd0, 6'd0, 16'd0}, NoGps}, 1'b1,
      '{'{13'd8191, 30'd518400000}, NoCal}},
    '{'{OpCalToGps, '{12'd1980, 4'd1, 5'd13, 5'd0, 6'd0, 16'd0}, NoGps}, 1'b1,
      '{'{13'd1, 30'd0}, NoCal}},
    '{'{OpGpsToCal, NoCal, '{13'd0, 30'd0}}, 1'b1,
      '{NoGps, '{12'd1980, 4'd1, 5'd6, 5'd0, 6'd0, 16'd0}}},
    '{'{OpGpsToCal, NoCal, '{13'd0, 30'd604799999}}, 1'b1,
      '{NoGps, '{12'd1980, 4'd1, 5'd12, 5'd23, 6'd59, 16'd59999}}},
    '{'{OpCalToGps, '{12'd2000, 4'd0, 5'd15, 5'd6, 6'd30, 16'd1000}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd2000, 4'd15, 5'd15, 5'd6, 6'd30, 16'd1000}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd2099, 4'd12, 5'd31, 5'd31, 6'd63, 16'd65535}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd0, 4'd1, 5'd0, 5'd0, 6'd0, 16'd0}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 16'd59999}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd1980, 4'd1, 5'd0, 5'd0, 6'd0, 16'd0}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd2000, 4'd2, 5'd29, 5'd12, 6'd34, 16'd56789}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 16'd0}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 16'd0}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd1979, 4'd12, 5'd31, 5'd23, 6'd59, 16'd59999}, NoGps}, 1'b0, NoRes},
    '{'{OpCalToGps, '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 16'd65535},
      '{13'd8191, 30'h3FFFFFFF}}, 1'b0, NoRes},
    '{'{OpGpsToCal, NoCal, '{13'd8191, 30'h3FFFFFFF}}, 1'b0, NoRes},
    '{'{OpGpsToCal, NoCal, '{13'd8191, 30'd604799999}}, 1'b0, NoRes},
    '{'{OpGpsToCal, NoCal, '{13'd1042, 30'd0}}, 1'b0, NoRes},
    '{'{OpGpsToCal, NoCal, '{13'd0, 30'h3FFFFFFF}}, 1'b0, NoRes},
    '{'{OpGpsToCal, '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 16'd65535},
      '{13'd2200, 30'd345600000}}, 1'b0, NoRes}
  };

  logic clk;
  logic rst_n;
  int   idle_pct = IdlePct;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  time_res_t pending_res [$];

  cgt_in_if  in_if ();
  cgt_out_if out_if ();

  calendar_gps_time_convert uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den != 0) && ((num < 0) != (den < 0))) q = q - 1;
    return q;
  endfunction

  function automatic time_res_t convert_time(input time_req_t req);
    time_res_t res;
    longint mon, yr, leap, days, total, wk, wms, msday, c, d, e, f, mm;
    res = '0;
    if (req.op == OpCalToGps) begin
      mon = longint'(req.cal.month);
      if (mon < 1) mon = 1;
      if (mon > 12) mon = 12;
      yr = longint'(req.cal.year) - GpsEpochYear;
      leap = floor_quot(yr, 4) + 1;
      if ((yr & 3) == 0 && mon <= 2) leap = leap - 1;
      days = yr * 365 + MonthStart[mon - 1] + longint'(req.cal.day) + leap - 6;
      total = days * DayMs + longint'(req.cal.hour) * HourMs
            + longint'(req.cal.minute) * MinuteMs + longint'(req.cal.millis);
      wk = floor_quot(total, WeekMs);
      res.gps.week = wk[12:0];
      res.gps.week_millis = 30'(total - wk * WeekMs);
    end else begin
      wms = longint'(req.gps.week_millis);
      msday = wms % DayMs;
      c = longint'(req.gps.week) * 7 + wms / DayMs + JulianEpoch + JulianOffset;
      // integer forms of the 365.25, 30.6001 and 122.1 steps
      d = (20 * c - 2442) / 7305;
      e = 365 * d + d / 4;
      f = ((c - e) * 10000) / 306001;
      mm = f - 1 - 12 * (f / 14);
      res.cal.day = 5'(c - e - (306001 * f) / 10000);
      res.cal.month = 4'(mm);
      res.cal.year = 12'(d - JulianYearBase - (7 + mm) / 10);
      res.cal.hour = 5'(msday / HourMs);
      res.cal.minute = 6'((msday / MinuteMs) % 60);
      res.cal.millis = 16'(msday % MinuteMs);
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // drives one item and waits for its handshake
  task automatic offer(input time_req_t req, input time_res_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.operation      <= req.op;
    in_if.cal_year       <= req.cal.year;
    in_if.cal_month      <= req.cal.month;
    in_if.cal_day        <= req.cal.day;
    in_if.cal_hour       <= req.cal.hour;
    in_if.cal_minute     <= req.cal.minute;
    in_if.cal_millis     <= req.cal.millis;
    in_if.in_week        <= req.gps.week;
    in_if.in_week_millis <= req.gps.week_millis;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_res.push_back(want);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin : result_check
    time_res_t want_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_res.size() == 0) begin
        $error("result item with none expected");
        mismatches++;
      end else begin
        want_r = pending_res.pop_front();
        compare_field("out_week", want_r.gps.week, out_if.out_week);
        compare_field("out_week_millis", want_r.gps.week_millis, out_if.out_week_millis);
        compare_field("out_year", want_r.cal.year, out_if.out_year);
        compare_field("out_month", want_r.cal.month, out_if.out_month);
        compare_field("out_day", want_r.cal.day, out_if.out_day);
        compare_field("out_hour", want_r.cal.hour, out_if.out_hour);
        compare_field("out_minute", want_r.cal.minute, out_if.out_minute);
        compare_field("out_millis", want_r.cal.millis, out_if.out_millis);
      end
    end
  end

  initial begin : stimulus
    time_req_t req;
    int        dim;
    int        i;
    int        n;
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.operation      <= OpCalToGps;
    in_if.cal_year       <= '0;
    in_if.cal_month      <= '0;
    in_if.cal_day        <= '0;
    in_if.cal_hour       <= '0;
    in_if.cal_minute     <= '0;
    in_if.cal_millis     <= '0;
    in_if.in_week        <= '0;
    in_if.in_week_millis <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NumDirected; i++) begin
      offer(Directed[i].req,
            Directed[i].known ? Directed[i].want : convert_time(Directed[i].req));
    end

    for (n = 0; n < NumRandom; n++) begin
      idle_pct = (n >= 1000 && n < 1300) ? 0 : IdlePct;
      // let the pipeline run dry once
      if (n == 700) begin
        in_if.valid <= 1'b0;
        do @(posedge clk); while (pending_res.size() != 0);
      end
      req.op              = 1'($urandom_range(1));
      req.cal.year        = 12'($urandom);
      req.cal.month       = 4'($urandom);
      req.cal.day         = 5'($urandom);
      req.cal.hour        = 5'($urandom);
      req.cal.minute      = 6'($urandom);
      req.cal.millis      = 16'($urandom);
      req.gps.week        = 13'($urandom);
      req.gps.week_millis = 30'($urandom);
      if ($urandom_range(99) < 85) begin
        if (req.op == OpCalToGps) begin
          req.cal.year = 12'(GpsEpochYear + $urandom_range(119));
          req.cal.month = 4'(1 + $urandom_range(11));
          unique case (req.cal.month)
            4'd2: dim = (req.cal.year % 4 == 0) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: dim = 30;
            default: dim = 31;
          endcase
          req.cal.day    = 5'(1 + $urandom_range(dim - 1));
          req.cal.hour   = 5'($urandom_range(23));
          req.cal.minute = 6'($urandom_range(59));
          req.cal.millis = 16'($urandom_range(59999));
        end else begin
          req.gps.week_millis = 30'($urandom_range(604799999));
        end
      end
      offer(req, convert_time(req));
    end

    in_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
